FILE: rtl/core/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 edge-clamped box blur core.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_ADDR_W = 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    // job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int COORD_W = 10;
    localparam int SUM_W   = 12;

    // reciprocals scaled by 2^16, exact for sums below 2300
    localparam logic [13:0] RECIP_6 = 14'd10923;
    localparam logic [13:0] RECIP_9 = 14'd7282;
    localparam int RECIP_SHIFT = 16;

    typedef logic [23:0] pixel_t;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pix_in_t;

    typedef struct packed {
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic               run_last;
        logic               frame_done;
    } pix_out_t;

    // one window snapshot with what the back needs to emit its results
    typedef struct packed {
        pixel_t [8:0]       win;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] wlast;
        logic               top_ok;
        logic               left_ok;
        logic               last_row;
        logic               last_col;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

endpackage

FILE: rtl/core/bb3_front.sv
// ----------------------------------------------------------------------------
// bb3_front
// Accepts pixels, tracks raster position, keeps line buffers and the window,
// and queues a job for every pixel that completes at least one result.
// ----------------------------------------------------------------------------
module bb3_front #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bb3_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bb3_pkg::pix_in_t              in_data,
    input  logic [bb3_pkg::QAW:0]         q_count,
    output bb3_pkg::push_t                push
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WM1_RESET = ((bb3_pkg::FRAME_WIDTH_RESET < MAX_WIDTH) ?
                                bb3_pkg::FRAME_WIDTH_RESET : MAX_WIDTH) - 1;
    localparam int HM1_RESET = ((bb3_pkg::FRAME_HEIGHT_RESET < MAX_HEIGHT) ?
                                bb3_pkg::FRAME_HEIGHT_RESET : MAX_HEIGHT) - 1;

    logic [CW-1:0] wm1_reg, wm1_next;
    logic [RW-1:0] hm1_reg, hm1_next;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    logic          s1_valid_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_lrow_reg;
    logic          s1_lcol_reg;
    logic [CW-1:0] s1_wm1_reg;
    bb3_pkg::pixel_t s1_px_reg;

    logic [47:0]   lbuf_mem [MAX_WIDTH];
    logic [47:0]   lbuf_rd_reg;

    bb3_pkg::pixel_t [8:0] win_reg, win_next;

    logic accept;
    logic last_col, last_row;

    assign in_stall = (int'(q_count) + int'(s1_valid_reg)) >= bb3_pkg::QDEPTH;
    assign accept   = in_valid && !in_stall;
    assign last_col = (col_reg == wm1_reg);
    assign last_row = (row_reg == hm1_reg);

    // size registers hold size minus one, clamped
    always_comb
    begin
        if (cfg_data < 11'd2)
            wm1_next = CW'(1);
        else if (int'(cfg_data) > MAX_WIDTH)
            wm1_next = CW'(MAX_WIDTH - 1);
        else
            wm1_next = CW'(cfg_data - 11'd1);
        if (cfg_data < 11'd2)
            hm1_next = RW'(1);
        else if (int'(cfg_data) > MAX_HEIGHT)
            hm1_next = RW'(MAX_HEIGHT - 1);
        else
            hm1_next = RW'(cfg_data - 11'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg      <= CW'(WM1_RESET);
            hm1_reg      <= RW'(HM1_RESET);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (cfg_we)
            begin
                if (cfg_addr == bb3_pkg::CFG_FRAME_WIDTH)
                    wm1_reg <= wm1_next;
                else
                    hm1_reg <= hm1_next;
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_lrow_reg <= last_row;
            s1_lcol_reg <= last_col;
            s1_wm1_reg  <= wm1_reg;
            s1_px_reg   <= in_data;
        end
    end

    // line buffers: upper half older row, lower half newer row
    always_ff @(posedge clk)
    begin
        if (accept)
            lbuf_rd_reg <= lbuf_mem[col_reg];
        if (s1_valid_reg)
            lbuf_mem[s1_col_reg] <= {lbuf_rd_reg[23:0], s1_px_reg};
    end

    always_comb
    begin
        win_next = win_reg;
        for (int a = 0; a < 3; a++)
        begin
            win_next[a*3+0] = win_reg[a*3+1];
            win_next[a*3+1] = win_reg[a*3+2];
        end
        win_next[2] = lbuf_rd_reg[47:24];
        win_next[5] = lbuf_rd_reg[23:0];
        win_next[8] = s1_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (s1_valid_reg)
            win_reg <= win_next;
    end

    always_comb
    begin
        push.valid        = s1_valid_reg && (s1_row_reg != '0) && (s1_col_reg != '0);
        push.job.win      = win_next;
        push.job.row      = bb3_pkg::COORD_W'(s1_row_reg);
        push.job.col      = bb3_pkg::COORD_W'(s1_col_reg);
        push.job.wlast    = bb3_pkg::COORD_W'(s1_wm1_reg);
        push.job.top_ok   = (s1_row_reg >= RW'(2));
        push.job.left_ok  = (s1_col_reg >= CW'(2));
        push.job.last_row = s1_lrow_reg;
        push.job.last_col = s1_lcol_reg;
    end

endmodule

FILE: rtl/core/bb3_queue.sv
// ----------------------------------------------------------------------------
// bb3_queue
// Short job queue that decouples the front from the result back end.
// ----------------------------------------------------------------------------
module bb3_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bb3_pkg::push_t        push,
    input  logic                  pop,
    output logic                  head_valid,
    output bb3_pkg::job_t         head,
    output logic [bb3_pkg::QAW:0] count
);

    bb3_pkg::job_t               mem_reg [bb3_pkg::QDEPTH];
    logic [bb3_pkg::QAW-1:0]     wr_ptr_reg;
    logic [bb3_pkg::QAW-1:0]     rd_ptr_reg;
    logic [bb3_pkg::QAW:0]       count_reg;

    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push.valid && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push.valid)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_ptr_reg] <= push.job;
    end

endmodule

FILE: rtl/core/bb3_back.sv
// ----------------------------------------------------------------------------
// bb3_back
// Walks the results of each queued job, sums the clamped neighborhood and
// divides by the pixel count into the output register.
// ----------------------------------------------------------------------------
module bb3_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  bb3_pkg::job_t     head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output bb3_pkg::pix_out_t out_data
);

    typedef enum logic [1:0] {
        DIV4,
        DIV6,
        DIV9
    } div_t;

    typedef struct packed {
        logic [bb3_pkg::SUM_W-1:0]   sum_r;
        logic [bb3_pkg::SUM_W-1:0]   sum_g;
        logic [bb3_pkg::SUM_W-1:0]   sum_b;
        div_t                        div;
        logic [bb3_pkg::COORD_W-1:0] row;
        logic [bb3_pkg::COORD_W-1:0] col;
        logic                        last;
        logic                        done;
    } sum_stage_t;

    logic [1:0]  kind_reg, kind_next;
    logic        is_last;
    logic        row0_en, col0_en;
    logic        s_valid_reg, o_valid_reg;
    logic        o_free, s_load;
    sum_stage_t  s_reg, s_next;
    bb3_pkg::pix_out_t o_reg, o_next;
    logic [bb3_pkg::SUM_W-1:0] rnd;

    // kind bit 1: lower row result, bit 0: right column result
    always_comb
    begin
        is_last   = 1'b0;
        kind_next = 2'b00;
        if (!kind_reg[0] && head.last_col)
            kind_next = {kind_reg[1], 1'b1};
        else if (!kind_reg[1] && head.last_row)
            kind_next = 2'b10;
        else
            is_last = 1'b1;
    end

    assign o_free = !o_valid_reg || !out_stall;
    assign s_load = head_valid && (!s_valid_reg || o_free);
    assign pop    = s_load && is_last;

    assign row0_en = !kind_reg[1] && head.top_ok;
    assign col0_en = !kind_reg[0] && head.left_ok;

    always_comb
    begin
        logic en;
        s_next.sum_r = '0;
        s_next.sum_g = '0;
        s_next.sum_b = '0;
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                en = !((a == 0) && !row0_en) && !((b == 0) && !col0_en);
                if (en)
                begin
                    s_next.sum_r = s_next.sum_r + bb3_pkg::SUM_W'(head.win[a*3+b][23:16]);
                    s_next.sum_g = s_next.sum_g + bb3_pkg::SUM_W'(head.win[a*3+b][15:8]);
                    s_next.sum_b = s_next.sum_b + bb3_pkg::SUM_W'(head.win[a*3+b][7:0]);
                end
            end
        end
        // add half the divisor for round half up
        if (row0_en && col0_en)
        begin
            s_next.div = DIV9;
            rnd        = bb3_pkg::SUM_W'(4);
        end
        else if (row0_en || col0_en)
        begin
            s_next.div = DIV6;
            rnd        = bb3_pkg::SUM_W'(3);
        end
        else
        begin
            s_next.div = DIV4;
            rnd        = bb3_pkg::SUM_W'(2);
        end
        s_next.sum_r = s_next.sum_r + rnd;
        s_next.sum_g = s_next.sum_g + rnd;
        s_next.sum_b = s_next.sum_b + rnd;
        s_next.row   = kind_reg[1] ? head.row : head.row - 1'b1;
        s_next.col   = kind_reg[0] ? head.wlast : head.col - 1'b1;
        s_next.last  = is_last;
        s_next.done  = (kind_reg == 2'b11);
    end

    function automatic logic [7:0] scale(input logic [bb3_pkg::SUM_W-1:0] x,
                                         input div_t d);
        logic [25:0] prod;
        logic [7:0]  q;
        case (d)
            DIV6:
            begin
                prod = 26'(x) * 26'(bb3_pkg::RECIP_6);
                q    = prod[bb3_pkg::RECIP_SHIFT +: 8];
            end
            DIV9:
            begin
                prod = 26'(x) * 26'(bb3_pkg::RECIP_9);
                q    = prod[bb3_pkg::RECIP_SHIFT +: 8];
            end
            default:
            begin
                prod = '0;
                q    = x[9:2];
            end
        endcase
        return q;
    endfunction

    always_comb
    begin
        o_next.out_red    = scale(s_reg.sum_r, s_reg.div);
        o_next.out_green  = scale(s_reg.sum_g, s_reg.div);
        o_next.out_blue   = scale(s_reg.sum_b, s_reg.div);
        o_next.out_row    = s_reg.row;
        o_next.out_col    = s_reg.col;
        o_next.run_last   = s_reg.last;
        o_next.frame_done = s_reg.done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= 2'b00;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_load)
                kind_reg <= is_last ? 2'b00 : kind_next;
            if (!s_valid_reg || o_free)
                s_valid_reg <= head_valid;
            if (o_free)
                o_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_load)
            s_reg <= s_next;
        if (o_free && s_valid_reg)
            o_reg <= o_next;
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_reg;

endmodule

FILE: rtl/core/box_blur_3x3_edge_clamped_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clamped_core
// Streaming 3x3 box blur of RGB pixels with an edge-clamped kernel.
// ----------------------------------------------------------------------------
// Pixels enter on in_valid/in_stall in raster order; a transfer happens when
// in_valid is high and in_stall low. Blurred pixels leave on out_valid/
// out_stall with their row and column, run_last on the final result of a
// transfer and frame_done on the bottom-right pixel of the frame.
// Pixel (i,j) comes out after pixel (i+1,j+1) has arrived, clamped at the
// right and bottom borders, so the last row leaves together with the row
// above it: up to four results per input pixel there.
// A first result passes the front stage, job queue, sum and output registers.
// Throughput: one pixel per cycle while out_stall is low and each pixel yields
// at most one result, set by the line buffer read and one output register; on
// the last row and column the back end emits one result per cycle and the job
// queue (four entries) fills, stalling the input.
// Reset clears counters, window, queue and output; sizes return to 640x480.
// Line buffer contents are not cleared. Writing a size restarts the frame.
// When out_stall is high the result is held and the queue backs up into
// in_stall; nothing is dropped.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clamped_core #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bb3_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  bb3_pkg::pix_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output bb3_pkg::pix_out_t              out_data
);

    bb3_pkg::push_t        push;
    logic                  pop;
    logic                  head_valid;
    bb3_pkg::job_t         head;
    logic [bb3_pkg::QAW:0] q_count;

    bb3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_count  (q_count),
        .push     (push)
    );

    bb3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    bb3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

FILE: rtl/core/bb3_checker.sv
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks of the box blur core, bound to the top level.
// ----------------------------------------------------------------------------
module bb3_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input bb3_pkg::pix_out_t out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // bottom-right pixel closes its transfer
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_done |-> out_data.run_last)
        else $error("frame_done without run_last");

    // results of one transfer follow without gaps
    a_run_dense: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.run_last |=> out_valid)
        else $error("gap inside a result run");

endmodule

bind box_blur_3x3_edge_clamped_core bb3_checker u_bb3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

FILE: dv/tb_box_blur_3x3_edge_clamped_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_edge_clamped_core
// Self-checking bench for the streaming 3x3 edge-clamped box blur core.
// ----------------------------------------------------------------------------
// Pixels are streamed in raster order through frames of several sizes,
// including clamped and maximum sizes and frames cut short by a size write.
// A built-in blur predictor keeps its own line buffers, window and counters
// and queues the blurred pixels each accepted pixel should produce; every
// output transfer is checked against the oldest queued pixel. Sender gaps and
// receiver stalls vary by phase, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_edge_clamped_core;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic                ret_unused_dummy_never = 1'b0;
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    bb3_pkg::cfg_index_t cfg_addr = bb3_pkg::CFG_FRAME_WIDTH;
    logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    bb3_pkg::pix_in_t    in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    bb3_pkg::pix_out_t   out_data;

    // predictor state
    logic [23:0] lb_older [bb3_pkg::MAX_WIDTH_DEF];
    logic [23:0] lb_newer [bb3_pkg::MAX_WIDTH_DEF];
    logic [23:0] win [3][3];
    int          cur_row;
    int          cur_col;
    int          img_w;
    int          img_h;

    bb3_pkg::pix_out_t blurred_q[$];
    idle_mode_t idle_mode = IDLE_NONE;
    int         hold_left = 0;
    int         pixels_sent = 0;
    bit         failed = 1'b0;

    box_blur_3x3_edge_clamped_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bb3_pkg::pix_out_t blur_at(int i, int j, int wr, int wc,
                                                  bit last, bit done);
        int r0, r1, c0, c1, sr, sg, sb, n;
        bb3_pkg::pix_out_t o;
        r0 = (i > 0) ? wr - 1 : wr;
        r1 = (i + 1 < img_h) ? wr + 1 : wr;
        c0 = (j > 0) ? wc - 1 : wc;
        c1 = (j + 1 < img_w) ? wc + 1 : wc;
        if (r1 > 2) r1 = 2;
        if (c1 > 2) c1 = 2;
        sr = 0; sg = 0; sb = 0; n = 0;
        for (int a = r0; a <= r1; a++)
            for (int b = c0; b <= c1; b++)
            begin
                sr += win[a][b][23:16];
                sg += win[a][b][15:8];
                sb += win[a][b][7:0];
                n++;
            end
        o.out_red    = 8'((sr + n / 2) / n);
        o.out_green  = 8'((sg + n / 2) / n);
        o.out_blue   = 8'((sb + n / 2) / n);
        o.out_row    = bb3_pkg::COORD_W'(i);
        o.out_col    = bb3_pkg::COORD_W'(j);
        o.run_last   = last;
        o.frame_done = done;
        return o;
    endfunction

    task automatic predict_blur(bb3_pkg::pix_in_t p);
        int ci, total, n;
        bit lr, lc;
        ci = (cur_col < bb3_pkg::MAX_WIDTH_DEF) ? cur_col : bb3_pkg::MAX_WIDTH_DEF - 1;
        lr = (cur_row + 1 == img_h);
        lc = (cur_col + 1 == img_w);
        for (int a = 0; a < 3; a++)
        begin
            win[a][0] = win[a][1];
            win[a][1] = win[a][2];
        end
        win[0][2] = lb_older[ci];
        win[1][2] = lb_newer[ci];
        win[2][2] = p;
        lb_older[ci] = lb_newer[ci];
        lb_newer[ci] = p;
        total = 0;
        n = 0;
        if (cur_row >= 1 && cur_col >= 1)
            total = (lc ? 2 : 1) * (lr ? 2 : 1);
        if (total > 0)
        begin
            n++;
            blurred_q.push_back(blur_at(cur_row - 1, cur_col - 1, 1, 1, n == total, 0));
            if (lc)
            begin
                n++;
                blurred_q.push_back(blur_at(cur_row - 1, img_w - 1, 1, 2, n == total, 0));
            end
            if (lr)
            begin
                n++;
                blurred_q.push_back(blur_at(cur_row, cur_col - 1, 2, 1, n == total, 0));
                if (lc)
                begin
                    n++;
                    blurred_q.push_back(blur_at(cur_row, img_w - 1, 2, 2, n == total, 1));
                end
            end
        end
        if (lc)
        begin
            cur_col = 0;
            cur_row = lr ? 0 : cur_row + 1;
        end
        else
            cur_col++;
    endtask

    // called right after a rising edge; leaves valid high after the transfer
    task automatic send_pixel(bb3_pkg::pix_in_t p);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 61 : (idle_mode == IDLE_BOTH) ? 7 : 0;
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (in_stall);
        predict_blur(p);
        pixels_sent++;
    endtask

    // wait until every queued pixel came out, plus the pipeline depth
    task automatic drain();
        in_valid <= 1'b0;
        while (blurred_q.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_size(bb3_pkg::cfg_index_t idx, int value);
        int v;
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= bb3_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        v = value & 'h7ff;
        if (v < 2) v = 2;
        if (idx == bb3_pkg::CFG_FRAME_WIDTH)
        begin
            if (v > bb3_pkg::MAX_WIDTH_DEF) v = bb3_pkg::MAX_WIDTH_DEF;
            img_w = v;
        end
        else
        begin
            if (v > bb3_pkg::MAX_HEIGHT_DEF) v = bb3_pkg::MAX_HEIGHT_DEF;
            img_h = v;
        end
        cur_row = 0;
        cur_col = 0;
    endtask

    // style: 0 random, 1 black, 2 white, 3 black/white checkerboard (column stripes when the width is odd)
    task automatic send_frame(int npix, int style);
        bb3_pkg::pix_in_t p;
        for (int k = 0; k < npix; k++)
        begin
            case (style)
                1: p = '0;
                2: p = '1;
                3: p = ((k + k / img_w) % 2) ? '1 : '0;
                default: p = bb3_pkg::pix_in_t'(24'($urandom));
            endcase
            send_pixel(p);
        end
    endtask

    task automatic test_reset_size();
        // default frame is 640 wide: a few pixels on row 0 give nothing
        send_frame(5, 0);
        drain();
    endtask

    task automatic test_corner_cases();
        write_size(bb3_pkg::CFG_FRAME_WIDTH, 0);
        write_size(bb3_pkg::CFG_FRAME_HEIGHT, 1);
        send_frame(4, 2);
        send_frame(4, 1);
        drain();
        write_size(bb3_pkg::CFG_FRAME_WIDTH, 3);
        write_size(bb3_pkg::CFG_FRAME_HEIGHT, 3);
        send_frame(9, 3);
        drain();
    endtask

    task automatic test_max_sizes();
        idle_mode = IDLE_BOTH;
        write_size(bb3_pkg::CFG_FRAME_WIDTH, 2047);
        write_size(bb3_pkg::CFG_FRAME_HEIGHT, 2047);
        send_frame(12, 0);
        drain();
        write_size(bb3_pkg::CFG_FRAME_WIDTH, 2);
        write_size(bb3_pkg::CFG_FRAME_HEIGHT, 1024);
        send_frame(16, 0);
        drain();
        idle_mode = IDLE_NONE;
    endtask

    task automatic test_backpressure();
        write_size(bb3_pkg::CFG_FRAME_WIDTH, 4);
        write_size(bb3_pkg::CFG_FRAME_HEIGHT, 3);
        hold_left = 300;
        send_frame(12, 0);
        send_frame(12, 0);
        drain();
    endtask

    task automatic test_random_frames();
        int npix;
        idle_mode_t modes[4] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
        for (int f = 0; pixels_sent < 180; f++)
        begin
            idle_mode = modes[f % 4];
            write_size(bb3_pkg::CFG_FRAME_WIDTH, $urandom_range(8, 2));
            write_size(bb3_pkg::CFG_FRAME_HEIGHT, $urandom_range(6, 2));
            npix = img_w * img_h;
            // now and then cut a frame short; the next size write restarts it
            if ($urandom_range(99) < 15)
                npix = $urandom_range(npix - 1, 1);
            else if ($urandom_range(99) < 30)
                npix = 2 * npix;
            if (npix > 180 - pixels_sent)
                npix = 180 - pixels_sent;
            send_frame(npix, 0);
            drain();
        end
        idle_mode = IDLE_NONE;
    endtask

    // receiver side: random stalls by phase, long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (idle_mode == IDLE_RECV)
            out_stall <= ($urandom_range(99) < 61);
        else if (idle_mode == IDLE_BOTH)
            out_stall <= ($urandom_range(99) < 7);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        bb3_pkg::pix_out_t exp_px;
        if (rst_n && out_valid && !out_stall)
        begin
            if (blurred_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual %p", $time, out_data);
                failed = 1'b1;
            end
            else
            begin
                exp_px = blurred_q.pop_front();
                if (out_data !== exp_px)
                begin
                    $display("%0t: mismatch, expected %p actual %p", $time, exp_px, out_data);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        for (int k = 0; k < bb3_pkg::MAX_WIDTH_DEF; k++)
        begin
            lb_older[k] = '0;
            lb_newer[k] = '0;
        end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                win[a][b] = '0;
        cur_row = 0;
        cur_col = 0;
        img_w = bb3_pkg::FRAME_WIDTH_RESET;
        img_h = bb3_pkg::FRAME_HEIGHT_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_size();
        test_corner_cases();
        test_max_sizes();
        test_backpressure();
        test_random_frames();
        if (!failed && blurred_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/bb3_pkg.sv
rtl/core/bb3_front.sv
rtl/core/bb3_queue.sv
rtl/core/bb3_back.sv
rtl/core/box_blur_3x3_edge_clamped_core.sv
rtl/core/bb3_checker.sv
dv/tb_box_blur_3x3_edge_clamped_core.sv
